>>> src/qdrpm_pkg.sv
// Shared types and constants for the quadrature decoder and RPM meter.
`default_nettype none

package qdrpm_pkg;

    localparam int CNT_W  = 32;
    localparam int TIME_W = 32;
    localparam int RPM_W  = 32;
    localparam int PPR_W  = 16;
    localparam int GEAR_W = 16;
    localparam int WIN_W  = 24;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [PPR_W-1:0]  PPR_RESET  = 16'd7;
    localparam logic [GEAR_W-1:0] GEAR_RESET = 16'd100;
    localparam logic [WIN_W-1:0]  WIN_RESET  = 24'd50000;

    // 60e6 us/min * 256 (Q8)
    localparam int                SCALE_W   = 34;
    localparam logic [SCALE_W-1:0] RPM_SCALE = 34'd15360000000;
    localparam logic [31:0]       SCALE_LO  = RPM_SCALE[31:0];
    localparam logic [1:0]        SCALE_HI  = RPM_SCALE[33:32];

    localparam int PROD_W = PPR_W + GEAR_W;   // ppr * gear
    localparam int DEN_W  = PROD_W + 2;       // times 4 for quadrature decoding
    localparam int DIV_W  = DEN_W + TIME_W;   // divisor and numerator width

    localparam logic [RPM_W-1:0] RPM_MAX = 32'h7FFF_FFFF;
    localparam logic [RPM_W-1:0] RPM_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        KIND_EDGE_A = 2'd0,
        KIND_EDGE_B = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_PPR    = 2'd0,
        REG_GEAR   = 2'd1,
        REG_WINDOW = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]        kind;
        logic              level_a;
        logic              level_b;
        logic [TIME_W-1:0] time_us;
    } t_in_req;

    typedef struct packed {
        logic signed [CNT_W-1:0] position_count;
        logic signed [RPM_W-1:0] rpm_q8;
        logic                    rpm_updated;
    } t_out_req;

    typedef struct packed {
        logic [PPR_W-1:0]  ppr;
        logic [GEAR_W-1:0] gear;
        logic [WIN_W-1:0]  window;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0]  position_count;
        logic [CNT_W-1:0]  delta;
        logic [TIME_W-1:0] dt;
        logic              upd;
    } t_job;

endpackage

`default_nettype wire

>>> src/quadrature_decoder_rpm_meter.sv
// Top level: quadrature decoder with windowed RPM measurement and APB registers.
//
// The front end takes one request per cycle while the queue is not full:
// edges and count clears update the position count at once, and speed updates
// check the window against the timestamp. Each request becomes a job in a
// QUEUE_DEPTH-entry queue. The back end retires most jobs as it dequeues them;
// a speed update that recomputes the RPM holds the back end through a dequeue,
// 3 multiply stages, 66 steps of the one-bit-per-cycle restoring divider and a
// saturate/issue step. The queue keeps accepting requests during that time
// until it fills, then o_in_stall rises.
// Registers: 0x0 pulses per motor rev, 0x4 gear ratio, 0x8 window in us.
`default_nettype none

module quadrature_decoder_rpm_meter #(
    parameter int QUEUE_DEPTH = qdrpm_pkg::QUEUE_DEPTH
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    input  qdrpm_pkg::t_in_req              i_in_req,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output qdrpm_pkg::t_out_req             o_out_req,
    input  wire                             i_out_stall,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [qdrpm_pkg::ADDR_W-1:0]     paddr,
    input  wire [qdrpm_pkg::DATA_W-1:0]     pwdata,
    output logic [qdrpm_pkg::DATA_W-1:0]    prdata,
    output logic                            pready
);

    qdrpm_pkg::t_cfg  r_cfg, n_cfg;
    qdrpm_pkg::t_job  push_job;
    qdrpm_pkg::t_job  pop_job;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    logic             wr_en;
    qdrpm_pkg::t_reg_idx reg_idx;

    always_comb begin
        pready  = 1'b1;
        wr_en   = psel && penable && pwrite;
        reg_idx = qdrpm_pkg::t_reg_idx'(paddr[qdrpm_pkg::ADDR_W-1:2]);
        n_cfg   = r_cfg;
        prdata  = '0;
        case (reg_idx)
            qdrpm_pkg::REG_PPR: begin
                prdata = qdrpm_pkg::DATA_W'(r_cfg.ppr);
                if (wr_en) begin
                    n_cfg.ppr = pwdata[qdrpm_pkg::PPR_W-1:0];
                end
            end
            qdrpm_pkg::REG_GEAR: begin
                prdata = qdrpm_pkg::DATA_W'(r_cfg.gear);
                if (wr_en) begin
                    n_cfg.gear = pwdata[qdrpm_pkg::GEAR_W-1:0];
                end
            end
            qdrpm_pkg::REG_WINDOW: begin
                prdata = qdrpm_pkg::DATA_W'(r_cfg.window);
                if (wr_en) begin
                    n_cfg.window = pwdata[qdrpm_pkg::WIN_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ppr    <= qdrpm_pkg::PPR_RESET;
            r_cfg.gear   <= qdrpm_pkg::GEAR_RESET;
            r_cfg.window <= qdrpm_pkg::WIN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    qdrpm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_req),
        .o_in_stall (o_in_stall),
        .i_cfg      (r_cfg),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    qdrpm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    qdrpm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (empty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

>>> src/qdrpm_front.sv
// Front end: position counting, window check and job issue.
`default_nettype none

module qdrpm_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  qdrpm_pkg::t_in_req   i_in_req,
    output logic                 o_in_stall,
    input  qdrpm_pkg::t_cfg      i_cfg,
    input  wire                  i_full,
    output logic                 o_push,
    output qdrpm_pkg::t_job      o_job
);

    logic [qdrpm_pkg::CNT_W-1:0]  r_count, n_count;
    logic [qdrpm_pkg::CNT_W-1:0]  r_wsc, n_wsc;
    logic [qdrpm_pkg::TIME_W-1:0] r_wst, n_wst;

    logic                         accept;
    logic [qdrpm_pkg::TIME_W-1:0] dt;
    logic [qdrpm_pkg::TIME_W-1:0] win;
    logic                         upd;

    always_comb begin
        accept  = i_in_valid && !i_full;
        n_count = r_count;
        n_wsc   = r_wsc;
        n_wst   = r_wst;
        upd     = 1'b0;
        dt      = i_in_req.time_us - r_wst;
        win     = (i_cfg.window == '0) ? qdrpm_pkg::TIME_W'(1)
                                       : qdrpm_pkg::TIME_W'(i_cfg.window);
        case (qdrpm_pkg::t_kind'(i_in_req.kind))
            qdrpm_pkg::KIND_EDGE_A: begin
                n_count = (i_in_req.level_a == i_in_req.level_b)
                        ? r_count + qdrpm_pkg::CNT_W'(1) : r_count - qdrpm_pkg::CNT_W'(1);
            end
            qdrpm_pkg::KIND_EDGE_B: begin
                n_count = (i_in_req.level_a != i_in_req.level_b)
                        ? r_count + qdrpm_pkg::CNT_W'(1) : r_count - qdrpm_pkg::CNT_W'(1);
            end
            qdrpm_pkg::KIND_UPDATE: begin
                if (dt >= win) begin
                    upd   = 1'b1;
                    n_wsc = r_count;
                    n_wst = i_in_req.time_us;
                end
            end
            qdrpm_pkg::KIND_CLEAR: begin
                n_count = '0;
                n_wsc   = '0;
            end
            default: begin
            end
        endcase
        o_job.position_count = n_count;
        o_job.delta          = r_count - r_wsc;
        o_job.dt             = dt;
        o_job.upd            = upd;
        o_push               = accept;
        o_in_stall           = i_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wsc   <= '0;
            r_wst   <= '0;
        end else if (accept) begin
            r_count <= n_count;
            r_wsc   <= n_wsc;
            r_wst   <= n_wst;
        end
    end

endmodule

`default_nettype wire

>>> src/qdrpm_queue.sv
// Job queue between the front end and the speed unit.
`default_nettype none

module qdrpm_queue #(
    parameter int DEPTH = qdrpm_pkg::QUEUE_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  qdrpm_pkg::t_job   i_job,
    output logic              o_full,
    input  wire               i_pop,
    output qdrpm_pkg::t_job   o_job,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    qdrpm_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [FILL_W-1:0]  r_fill, n_fill;

    always_comb begin
        o_full  = (r_fill == FILL_W'(DEPTH));
        o_empty = (r_fill == '0);
        o_job   = r_mem[r_rd];
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_fill  = r_fill;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> src/qdrpm_back.sv
// Back end: speed computation (multiply, restoring divide, saturate) and output register.
`default_nettype none

module qdrpm_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  qdrpm_pkg::t_cfg      i_cfg,
    input  wire                  i_empty,
    input  qdrpm_pkg::t_job      i_job,
    output logic                 o_pop,
    output logic                 o_out_valid,
    output qdrpm_pkg::t_out_req  o_out_req,
    input  wire                  i_out_stall
);

    localparam int DIV_W  = qdrpm_pkg::DIV_W;
    localparam int CNT_W  = qdrpm_pkg::CNT_W;
    localparam int RPM_W  = qdrpm_pkg::RPM_W;
    localparam int STEP_W = $clog2(DIV_W);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL1 = 6'b000010,
        S_MUL2 = 6'b000100,
        S_MUL3 = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state                       r_state, n_state;
    logic                         r_out_valid, n_out_valid;
    qdrpm_pkg::t_out_req          r_out_req, n_out_req;
    logic [RPM_W-1:0]             r_speed, n_speed;
    logic [CNT_W-1:0]             r_pos, n_pos;
    logic                         r_neg, n_neg;
    logic [CNT_W-1:0]             r_mag, n_mag;
    logic [qdrpm_pkg::TIME_W-1:0] r_dt, n_dt;
    logic [63:0]                  r_p0, n_p0;
    logic [qdrpm_pkg::PROD_W-1:0] r_pg, n_pg;
    logic [63:0]                  r_dlo, n_dlo;
    logic [qdrpm_pkg::DEN_W-1:0]  r_dhi, n_dhi;
    logic [DIV_W-1:0]             r_num, n_num;
    logic [DIV_W-1:0]             r_den, n_den;
    logic [DIV_W-1:0]             r_rem, n_rem;
    logic [STEP_W-1:0]            r_step, n_step;

    logic                         out_free;
    logic                         den_zero;
    logic [qdrpm_pkg::DEN_W-1:0]  den;
    logic [DIV_W:0]               shifted;
    logic [DIV_W:0]               diff;
    logic                         ge;
    logic                         q_big;
    logic [RPM_W-1:0]             sat;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        den_zero = (i_cfg.ppr == '0) || (i_cfg.gear == '0);
        den      = {r_pg, 2'b00};
        shifted  = {r_rem, r_num[DIV_W-1]};
        diff     = shifted - {1'b0, r_den};
        ge       = (shifted >= {1'b0, r_den});
        q_big    = |r_num[DIV_W-1:RPM_W-1];
        if (r_neg) begin
            sat = q_big ? qdrpm_pkg::RPM_MIN : (~r_num[RPM_W-1:0] + RPM_W'(1));
        end else begin
            sat = q_big ? qdrpm_pkg::RPM_MAX : r_num[RPM_W-1:0];
        end

        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_req   = r_out_req;
        n_speed     = r_speed;
        n_pos       = r_pos;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_dt        = r_dt;
        n_p0        = r_p0;
        n_pg        = r_pg;
        n_dlo       = r_dlo;
        n_dhi       = r_dhi;
        n_num       = r_num;
        n_den       = r_den;
        n_rem       = r_rem;
        n_step      = r_step;
        o_pop       = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop                    = 1'b1;
                    n_out_req.position_count = i_job.position_count;
                    n_out_req.rpm_updated    = i_job.upd;
                    if (!i_job.upd) begin
                        n_out_valid      = 1'b1;
                        n_out_req.rpm_q8 = r_speed;
                    end else if (i_job.delta == '0) begin
                        n_out_valid      = 1'b1;
                        n_speed          = '0;
                        n_out_req.rpm_q8 = '0;
                    end else if (den_zero) begin
                        n_out_valid      = 1'b1;
                        n_speed          = i_job.delta[CNT_W-1] ? qdrpm_pkg::RPM_MIN
                                                                : qdrpm_pkg::RPM_MAX;
                        n_out_req.rpm_q8 = n_speed;
                    end else begin
                        n_pos   = i_job.position_count;
                        n_neg   = i_job.delta[CNT_W-1];
                        n_mag   = i_job.delta[CNT_W-1] ? (~i_job.delta + CNT_W'(1))
                                                       : i_job.delta;
                        n_dt    = i_job.dt;
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                n_p0    = 64'(r_mag) * 64'(qdrpm_pkg::SCALE_LO);
                n_pg    = qdrpm_pkg::PROD_W'(i_cfg.ppr) * qdrpm_pkg::PROD_W'(i_cfg.gear);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_num   = DIV_W'(r_p0)
                        + (DIV_W'(34'(r_mag) * 34'(qdrpm_pkg::SCALE_HI)) << 32);
                n_dlo   = 64'(den[31:0]) * 64'(r_dt);
                n_dhi   = qdrpm_pkg::DEN_W'(den[qdrpm_pkg::DEN_W-1:32])
                        * qdrpm_pkg::DEN_W'(r_dt);
                n_state = S_MUL3;
            end
            S_MUL3: begin
                n_den   = DIV_W'(r_dlo) + (DIV_W'(r_dhi) << 32);
                n_rem   = '0;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
                n_num  = {r_num[DIV_W-2:0], ge};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_req.position_count = r_pos;
                    n_out_req.rpm_q8         = sat;
                    n_out_req.rpm_updated    = 1'b1;
                    n_speed                  = sat;
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_speed     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_speed     <= n_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_req <= n_out_req;
        r_pos     <= n_pos;
        r_neg     <= n_neg;
        r_mag     <= n_mag;
        r_dt      <= n_dt;
        r_p0      <= n_p0;
        r_pg      <= n_pg;
        r_dlo     <= n_dlo;
        r_dhi     <= n_dhi;
        r_num     <= n_num;
        r_den     <= n_den;
        r_rem     <= n_rem;
        r_step    <= n_step;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    a_speed_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_req.rpm_q8 == r_speed)
        else $error("held result disagrees with stored speed");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_den)
        else $error("divider remainder out of range");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == STEP_W'(DIV_W - 1)) |=> r_state == S_DONE)
        else $error("divider did not finish on its last step");

endmodule

`default_nettype wire
